[rtl/cmc_pkg.sv]
`default_nettype none
package cmc_pkg;
    localparam int unsigned PosW = 20;
    localparam int unsigned ConfW = 17;
    localparam int unsigned SumW = 37;
    localparam int unsigned CntW = 21;
    localparam int unsigned MaxObjectPixels = 1048576;
    localparam int unsigned QuotW = 34;   // floor(dist2*2^32/max2) <= 2^32
    localparam int unsigned DistW = 18;   // dist2 <= 3*255^2
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 17;
    localparam logic [ConfW-1:0] ConfOne = 17'd65536;

    typedef enum logic [CfgIdxW-1:0] {
        REG_TARGET_RED = 3'd0,
        REG_TARGET_GREEN = 3'd1,
        REG_TARGET_BLUE = 3'd2,
        REG_PIXEL_THR = 3'd3,
        REG_OBJECT_THR = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] pixel_red;
        logic [7:0] pixel_green;
        logic [7:0] pixel_blue;
        logic [PosW-1:0] pixel_position;
        logic last_pixel;
    } t_pix;

    typedef struct packed {
        logic [PosW-1:0] mask_position;
        logic [ConfW-1:0] mask_value;
        logic object_done;
        logic [ConfW-1:0] mean_confidence;
        logic colour_matches;
    } t_res;

    // queue entry between front and back
    typedef struct packed {
        logic [DistW-1:0] dist2;
        logic [PosW-1:0] pos;
        logic last;
    } t_job;
endpackage
`default_nettype wire

[rtl/cmc_pix_if.sv]
`default_nettype none
interface cmc_pix_if;
    logic valid;
    logic ready;
    cmc_pkg::t_pix data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/cmc_res_if.sv]
`default_nettype none
interface cmc_res_if;
    logic valid;
    logic ready;
    cmc_pkg::t_res data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/color_match_confidence_unit.sv]
// Color match confidence unit.
// Input channel s_in carries one pixel (RGB, position, last flag); output
// channel m_out carries one result per pixel: mask position and value, and
// on the last pixel the object's mean confidence and match flag.
// Registers (target RGB, pixel and object thresholds) are written through
// i_cfg_we/i_cfg_idx/i_cfg_data; the user must write them only while no
// pixel is in flight, as the block does not enforce this. The front stage
// registers the squared distance and feeds a two-entry queue; the back unit
// takes one pixel at a time and no new one before it is done: restoring
// division, square root, accumulation, the mean on a last pixel, then the
// load of the output register. The divider, the root unit and the separate
// mean divider are all bit-serial.
// Reset restores register defaults and clears sum, count and all queues.
// When the receiver stalls, the result register holds; the back unit
// waits, the queue fills, then the input deasserts ready.
`default_nettype none
module color_match_confidence_unit (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_cfg_we,
    input wire logic [cmc_pkg::CfgIdxW-1:0] i_cfg_idx,
    input wire logic [cmc_pkg::CfgDataW-1:0] i_cfg_data,
    cmc_pix_if.sink s_in,
    cmc_res_if.source m_out
);
    import cmc_pkg::*;

    logic [7:0] r_tr, r_tg, r_tb;
    logic [ConfW-1:0] r_pthr, r_othr;
    logic f_valid, f_ready, q_valid, q_ready;
    t_job f_job, q_job;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tr <= '0;
            r_tg <= '0;
            r_tb <= '0;
            r_pthr <= 17'd26214;
            r_othr <= 17'd32768;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TARGET_RED: r_tr <= i_cfg_data[7:0];
                REG_TARGET_GREEN: r_tg <= i_cfg_data[7:0];
                REG_TARGET_BLUE: r_tb <= i_cfg_data[7:0];
                REG_PIXEL_THR: r_pthr <= i_cfg_data;
                REG_OBJECT_THR: r_othr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    cmc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_tr(r_tr), .i_tg(r_tg), .i_tb(r_tb),
        .s_in(s_in), .o_valid(f_valid), .o_job(f_job), .i_ready(f_ready)
    );

    cmc_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(f_valid), .i_job(f_job),
        .o_ready(f_ready), .o_valid(q_valid), .o_job(q_job), .i_ready(q_ready)
    );

    cmc_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_tr(r_tr), .i_tg(r_tg), .i_tb(r_tb),
        .i_pthr(r_pthr), .i_othr(r_othr), .i_valid(q_valid), .i_job(q_job),
        .o_ready(q_ready), .m_out(m_out)
    );
endmodule
`default_nettype wire

[rtl/cmc_front.sv]
`default_nettype none
module cmc_front (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic [7:0] i_tr,
    input wire logic [7:0] i_tg,
    input wire logic [7:0] i_tb,
    cmc_pix_if.sink s_in,
    output logic o_valid,
    output cmc_pkg::t_job o_job,
    input wire logic i_ready
);
    import cmc_pkg::*;

    logic [7:0] dr, dg, db;
    logic [DistW-1:0] n_d2;
    logic r_valid;
    t_job r_job;

    // absolute channel differences and squared distance
    always_comb begin
        dr = (s_in.data.pixel_red > i_tr) ? s_in.data.pixel_red - i_tr
                                          : i_tr - s_in.data.pixel_red;
        dg = (s_in.data.pixel_green > i_tg) ? s_in.data.pixel_green - i_tg
                                            : i_tg - s_in.data.pixel_green;
        db = (s_in.data.pixel_blue > i_tb) ? s_in.data.pixel_blue - i_tb
                                           : i_tb - s_in.data.pixel_blue;
        n_d2 = DistW'(dr * dr) + DistW'(dg * dg) + DistW'(db * db);
    end

    assign s_in.ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_in.ready) begin
            r_valid <= s_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_in.ready && s_in.valid) begin
            r_job <= '{dist2: n_d2, pos: s_in.data.pixel_position,
                       last: s_in.data.last_pixel};
        end
    end

    assign o_valid = r_valid;
    assign o_job = r_job;
endmodule
`default_nettype wire

[rtl/cmc_queue.sv]
`default_nettype none
module cmc_queue (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_valid,
    input cmc_pkg::t_job i_job,
    output logic o_ready,
    output logic o_valid,
    output cmc_pkg::t_job o_job,
    input wire logic i_ready
);
    import cmc_pkg::*;

    t_job r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign push = i_valid && o_ready;
    assign pop = o_valid && i_ready;
    assign o_job = r_mem[r_rp];

    // advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_job;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt != 2'd3)
        else $error("queue count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> (r_wp == r_rp))
        else $error("empty queue pointers differ");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> (r_wp == r_rp))
        else $error("full queue pointers differ");
endmodule
`default_nettype wire

[rtl/cmc_back.sv]
`default_nettype none
module cmc_back (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic [7:0] i_tr,
    input wire logic [7:0] i_tg,
    input wire logic [7:0] i_tb,
    input wire logic [cmc_pkg::ConfW-1:0] i_pthr,
    input wire logic [cmc_pkg::ConfW-1:0] i_othr,
    input wire logic i_valid,
    input cmc_pkg::t_job i_job,
    output logic o_ready,
    cmc_res_if.source m_out
);
    import cmc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV = 5'b00010,
        S_SQRT = 5'b00100,
        S_MEAN = 5'b01000,
        S_OUT = 5'b10000
    } t_state;

    t_state r_state;
    logic [5:0] r_step;
    // divider: dividend dist2<<32 (50 bits), restoring
    logic [DistW+32-1:0] r_num;
    logic [DistW+1:0] r_rem;
    logic [QuotW-1:0] r_quo;
    // square root
    logic [QuotW-1:0] r_sv;
    logic [17:0] r_root;
    logic [19:0] r_srem;
    // mean divider
    logic [SumW-1:0] r_sum, r_mnum;
    logic [CntW-1:0] r_cnt;
    logic [CntW:0] r_mrem;
    logic [ConfW-1:0] r_mq;
    logic [ConfW-1:0] r_mask;
    t_job r_job;
    t_res r_res;
    logic r_ovalid;
    logic [DistW-1:0] max2;
    logic [7:0] fr, fg, fb;
    logic [DistW+1:0] trem;
    logic [19:0] strial, srem2;
    logic [ConfW-1:0] conf;
    logic [CntW:0] mtrem;
    logic counting;

    // farthest cube corner
    always_comb begin
        fr = (i_tr > 8'd127) ? i_tr : 8'd255 - i_tr;
        fg = (i_tg > 8'd127) ? i_tg : 8'd255 - i_tg;
        fb = (i_tb > 8'd127) ? i_tb : 8'd255 - i_tb;
        max2 = DistW'(fr * fr) + DistW'(fg * fg) + DistW'(fb * fb);
        trem = {r_rem[DistW:0], r_num[DistW+31]};
        srem2 = {r_srem[17:0], r_sv[QuotW-1 -: 2]};
        strial = {r_root, 2'b01};
        conf = ConfOne - ((r_root > 18'd65536) ? ConfOne : ConfW'(r_root));
        mtrem = {r_mrem[CntW-1:0], r_mnum[SumW-1]};
        counting = (r_cnt < CntW'(MaxObjectPixels));
    end

    assign o_ready = (r_state == S_IDLE);
    assign m_out.valid = r_ovalid;
    assign m_out.data = r_res;

    // raise the result valid on load, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_OUT && (!r_ovalid || m_out.ready)) begin
            r_ovalid <= 1'b1;
        end else if (m_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sum <= '0;
            r_cnt <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    r_job <= i_job;
                    r_num <= {i_job.dist2, 32'd0};
                    r_rem <= '0;
                    r_quo <= '0;
                    r_step <= 6'd50;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // one quotient bit per cycle; quotient fits 34 bits
                    if (trem >= {2'b00, max2}) begin
                        r_rem <= trem - {2'b00, max2};
                        r_quo <= {r_quo[QuotW-2:0], 1'b1};
                    end else begin
                        r_rem <= trem;
                        r_quo <= {r_quo[QuotW-2:0], 1'b0};
                    end
                    r_num <= r_num << 1;
                    if (r_step == 6'd1) begin
                        r_state <= S_SQRT;
                        r_step <= 6'd17;
                        r_root <= '0;
                        r_srem <= '0;
                    end else begin
                        r_step <= r_step - 6'd1;
                    end
                end
                S_SQRT: begin
                    if (srem2 >= strial) begin
                        r_srem <= srem2 - strial;
                        r_root <= {r_root[16:0], 1'b1};
                    end else begin
                        r_srem <= srem2;
                        r_root <= {r_root[16:0], 1'b0};
                    end
                    r_sv <= r_sv << 2;
                    if (r_step == 6'd1) begin
                        r_state <= S_MEAN;
                        r_step <= 6'd0;
                    end else begin
                        r_step <= r_step - 6'd1;
                    end
                end
                S_MEAN: if (r_step == 6'd0) begin
                    // apply threshold, update totals
                    r_mask <= (conf > i_pthr) ? conf : '0;
                    if (counting) begin
                        r_cnt <= r_cnt + CntW'(1);
                        r_sum <= r_sum + SumW'((conf > i_pthr) ? conf : '0);
                        r_mnum <= r_sum + SumW'((conf > i_pthr) ? conf : '0);
                    end else begin
                        r_mnum <= r_sum;
                    end
                    r_mrem <= '0;
                    r_mq <= '0;
                    r_step <= r_job.last ? 6'd37 : 6'd63;
                end else if (r_step == 6'd63 || !r_job.last) begin
                    r_state <= S_OUT;
                end else begin
                    // mean: one bit per cycle, keep low 17 quotient bits
                    if (mtrem >= {1'b0, r_cnt}) begin
                        r_mrem <= mtrem - {1'b0, r_cnt};
                        r_mq <= {r_mq[ConfW-2:0], 1'b1};
                    end else begin
                        r_mrem <= mtrem;
                        r_mq <= {r_mq[ConfW-2:0], 1'b0};
                    end
                    r_mnum <= r_mnum << 1;
                    r_step <= r_step - 6'd1;
                    if (r_step == 6'd1) r_state <= S_OUT;
                end
                S_OUT: if (!r_ovalid || m_out.ready) begin
                    r_res.mask_position <= r_job.pos;
                    r_res.mask_value <= r_mask;
                    r_res.object_done <= r_job.last;
                    r_res.mean_confidence <= r_job.last ? r_mq : '0;
                    r_res.colour_matches <= r_job.last && (r_mq > i_othr);
                    if (r_job.last) begin
                        r_sum <= '0;
                        r_cnt <= '0;
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            // load radicand when division ends
            if (r_state == S_DIV && r_step == 6'd1) r_sv <= r_quo[QuotW-2:0] << 1
                | QuotW'(trem >= {2'b00, max2});
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state not one-hot");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_job.last && !r_ovalid) |=> (r_cnt == '0))
        else $error("count not cleared after object");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt <= CntW'(MaxObjectPixels)))
        else $error("pixel count above limit");
endmodule
`default_nettype wire

[bench/tb_color_match_confidence_unit.sv]
`default_nettype none
module tb_color_match_confidence_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import cmc_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0] i_cfg_idx = '0;
    logic [CfgDataW-1:0] i_cfg_data = '0;

    cmc_pix_if pix_ch ();
    cmc_res_if res_ch ();

    color_match_confidence_unit dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .s_in(pix_ch.source),
        .m_out(res_ch.sink)
    );

    always #5 i_clk = ~i_clk;

    // shadow of the block's registers and accumulator
    logic [7:0] tgt_r, tgt_g, tgt_b;
    logic [ConfW-1:0] pix_thr, obj_thr;
    logic [SumW-1:0] conf_sum;
    logic [CntW-1:0] pix_cnt;

    t_pix pending_pixels[$];
    t_res expected_results[$];
    int mismatch_count = 0;
    longint cycle_count = 0;
    bit stall_long = 1'b0;
    bit drain_req = 1'b0;
    int out_stall_len = 0;

    function automatic logic [63:0] root64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] far_sq(input logic [7:0] t);
        logic [63:0] f;
        f = (t > 8'd255 - t) ? t : 8'd255 - t;
        return f * f;
    endfunction

    function automatic logic [63:0] diff_sq(input logic [7:0] a, input logic [7:0] b);
        logic [63:0] d;
        d = (a > b) ? a - b : b - a;
        return d * d;
    endfunction

    // compute the result of one pixel and advance the accumulator
    function automatic t_res score_pixel(input t_pix p);
        t_res r;
        logic [63:0] max2, dist2, q, conf, mask, mean;
        max2 = far_sq(tgt_r) + far_sq(tgt_g) + far_sq(tgt_b);
        dist2 = diff_sq(p.pixel_red, tgt_r) + diff_sq(p.pixel_green, tgt_g)
              + diff_sq(p.pixel_blue, tgt_b);
        q = root64((dist2 << 32) / max2);
        if (q > 65536) q = 65536;
        conf = 65536 - q;
        mask = (conf > pix_thr) ? conf : 0;
        if (pix_cnt < MaxObjectPixels) begin
            pix_cnt = pix_cnt + 1'b1;
            conf_sum = SumW'(conf_sum + mask);
        end
        mean = 0;
        r = '0;
        r.mask_position = p.pixel_position;
        r.mask_value = mask[ConfW-1:0];
        r.object_done = p.last_pixel;
        if (p.last_pixel) begin
            if (pix_cnt != 0) mean = conf_sum / pix_cnt;
            if (mean > 65536) mean = 65536;
            r.mean_confidence = mean[ConfW-1:0];
            r.colour_matches = (mean > obj_thr);
            conf_sum = 0;
            pix_cnt = 0;
        end
        return r;
    endfunction

    task automatic report(input string what, input t_res got, input t_res want);
        $display("ERROR %s: got %h want %h", what, got, want);
        mismatch_count++;
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CfgDataW-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_TARGET_RED: tgt_r = val[7:0];
            REG_TARGET_GREEN: tgt_g = val[7:0];
            REG_TARGET_BLUE: tgt_b = val[7:0];
            REG_PIXEL_THR: pix_thr = val;
            REG_OBJECT_THR: obj_thr = val;
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (pending_pixels.size() != 0 || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    function automatic t_pix make_pixel(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b, input logic last);
        t_pix p;
        p.pixel_red = r;
        p.pixel_green = g;
        p.pixel_blue = b;
        p.pixel_position = PosW'($urandom_range(0, 1048575));
        p.last_pixel = last;
        return p;
    endfunction

    // random object of mostly near-target pixels
    task automatic queue_object(input int n);
        t_pix p;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 2) == 0)
                p = make_pixel(8'($urandom), 8'($urandom), 8'($urandom), k == n - 1);
            else
                p = make_pixel(8'(tgt_r + $urandom_range(0, 40) - 20),
                               8'(tgt_g + $urandom_range(0, 40) - 20),
                               8'(tgt_b + $urandom_range(0, 40) - 20), k == n - 1);
            pending_pixels.push_back(p);
        end
    endtask

    // driver: offer queued pixels with random gaps
    int in_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_ch.valid <= 1'b0;
            pix_ch.data <= '0;
        end else if (pix_ch.valid && pix_ch.ready) begin
            expected_results.push_back(score_pixel(pix_ch.data));
            pending_pixels.pop_front();
            in_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
            if (in_gap == 0 && pending_pixels.size() != 0 && !drain_req) begin
                pix_ch.data <= pending_pixels[0];
            end else begin
                pix_ch.valid <= 1'b0;
            end
        end else if (!pix_ch.valid) begin
            if (in_gap > 0) begin
                in_gap--;
            end else if (pending_pixels.size() != 0 && !drain_req) begin
                pix_ch.valid <= 1'b1;
                pix_ch.data <= pending_pixels[0];
            end
        end
    end

    // monitor: check each result and draw the receiver's stalls
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > 2000000) begin
            $display("Mismatches found");
            $finish;
        end
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (expected_results.size() == 0) begin
                    report("unexpected result", res_ch.data, '0);
                end else begin
                    t_res w;
                    w = expected_results.pop_front();
                    if (res_ch.data.mask_position !== w.mask_position)
                        report("mask_position", res_ch.data, w);
                    if (res_ch.data.mask_value !== w.mask_value)
                        report("mask_value", res_ch.data, w);
                    if (res_ch.data.object_done !== w.object_done)
                        report("object_done", res_ch.data, w);
                    if (res_ch.data.mean_confidence !== w.mean_confidence)
                        report("mean_confidence", res_ch.data, w);
                    if (res_ch.data.colour_matches !== w.colour_matches)
                        report("colour_matches", res_ch.data, w);
                end
                out_stall_len = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 14);
            end
            if (stall_long) begin
                res_ch.ready <= 1'b0;
            end else if (out_stall_len > 0) begin
                out_stall_len--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        int sent;
        tgt_r = 0; tgt_g = 0; tgt_b = 0;
        pix_thr = 26214; obj_thr = 32768;
        conf_sum = 0; pix_cnt = 0;
        pix_ch.valid = 1'b0;
        pix_ch.data = '0;
        res_ch.ready = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset settings, then corners, exact match and extremes
        pending_pixels.push_back(make_pixel(8'd0, 8'd0, 8'd0, 1'b0));
        pending_pixels.push_back(make_pixel(8'd255, 8'd255, 8'd255, 1'b1));
        wait_idle();
        write_reg(REG_TARGET_RED, 17'h1FF80);
        write_reg(REG_TARGET_GREEN, 17'd127);
        write_reg(REG_TARGET_BLUE, 17'd255);
        write_reg(REG_PIXEL_THR, 17'd0);
        write_reg(REG_OBJECT_THR, 17'd0);
        pending_pixels.push_back(make_pixel(8'd128, 8'd127, 8'd255, 1'b0));
        pending_pixels.push_back(make_pixel(8'd0, 8'd255, 8'd0, 1'b0));
        pending_pixels.push_back(make_pixel(8'd255, 8'd0, 8'd0, 1'b0));
        pending_pixels.push_back(make_pixel(8'd130, 8'd120, 8'd250, 1'b1));
        pending_pixels.push_back(make_pixel(8'd0, 8'd255, 8'd0, 1'b1));
        wait_idle();
        // thresholds above any confidence
        write_reg(REG_PIXEL_THR, 17'h1FFFF);
        write_reg(REG_OBJECT_THR, 17'd65536);
        pending_pixels.push_back(make_pixel(8'd128, 8'd127, 8'd255, 1'b1));
        wait_idle();
        write_reg(REG_PIXEL_THR, 17'd65535);
        write_reg(REG_OBJECT_THR, 17'd65535);
        pending_pixels.push_back(make_pixel(8'd128, 8'd127, 8'd255, 1'b1));
        pending_pixels.push_back(make_pixel(8'd128, 8'd127, 8'd255, 1'b0));
        pending_pixels.push_back(make_pixel(8'd128, 8'd127, 8'd254, 1'b1));
        wait_idle();

        // long receiver hold while the sender keeps offering items
        stall_long = 1'b1;
        queue_object(12);
        repeat (1500) @(posedge i_clk);
        stall_long = 1'b0;
        wait_idle();

        // random phases with fresh settings
        sent = 0;
        while (sent < 1800) begin
            write_reg(REG_TARGET_RED, 17'($urandom));
            write_reg(REG_TARGET_GREEN, 17'($urandom));
            write_reg(REG_TARGET_BLUE, 17'($urandom));
            write_reg(REG_PIXEL_THR, 17'($urandom_range(0, 3) == 0 ? $urandom :
                      $urandom_range(20000, 60000)));
            write_reg(REG_OBJECT_THR, 17'($urandom_range(0, 3) == 0 ? $urandom :
                      $urandom_range(10000, 50000)));
            for (int o = 0; o < 8; o++) begin
                int n;
                n = $urandom_range(1, 20);
                queue_object(n);
                sent += n;
            end
            // pause the sender until all results are back
            drain_req = 1'b1;
            while (expected_results.size() != 0) @(posedge i_clk);
            drain_req = 1'b0;
            wait_idle();
        end

        wait_idle();
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
`default_nettype wire

[sim.f]
rtl/cmc_pkg.sv
rtl/cmc_pix_if.sv
rtl/cmc_res_if.sv
rtl/cmc_front.sv
rtl/cmc_queue.sv
rtl/cmc_back.sv
rtl/color_match_confidence_unit.sv
bench/tb_color_match_confidence_unit.sv
